// File: src/caf_pkg.sv
package caf_pkg;

	localparam int NUM_FIELDS = 32;
	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int PLANE_W = $clog2(NUM_FIELDS);
	localparam int MAP_AW  = PLANE_W + ROW_W + COL_W;
	localparam int MAP_DEPTH = NUM_FIELDS * MAX_HEIGHT * MAX_WIDTH;

	localparam logic [15:0] ONE_Q15 = 16'd32768;

	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);

	// register indexes of the configuration port
	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_FLOOR     = 3'd1;
	localparam logic [2:0] REG_STRIDE    = 3'd2;
	localparam logic [2:0] REG_WIDTH     = 3'd3;
	localparam logic [2:0] REG_HEIGHT    = 3'd4;
	localparam logic [2:0] REG_FIELDS    = 3'd5;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CELL = 1'b1;

	localparam logic DIR_FORWARD  = 1'b0;
	localparam logic DIR_BACKWARD = 1'b1;

	// effective (clamped) configuration
	typedef struct packed {
		logic [15:0] threshold;
		logic [15:0] floor_w;
		logic [6:0]  stride;
		logic [7:0]  width;
		logic [7:0]  height;
		logic [6:0]  fields;
	} caf_cfg_t;

	typedef logic signed [21:0] coord_t;

	typedef struct packed {
		logic [4:0]  field;
		logic        keep_fwd;
		logic        keep_bwd;
		logic [15:0] score_fwd;
		logic [15:0] score_bwd;
		coord_t [3:0] first;
		coord_t [3:0] second;
	} caf_rec_t;

	typedef struct packed {
		logic [QPTR_W:0] count;
		logic            not_empty;
	} caf_qstat_t;

	function automatic coord_t scale_coord(logic signed [15:0] v, logic [6:0] s);
		logic signed [23:0] p;
		p = v * $signed({1'b0, s});
		return p[21:0];
	endfunction

endpackage

// File: src/caf_if.sv
interface caf_cell_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [4:0]         field_index;
	logic [15:0]        map_value;
	logic [15:0]        confidence;
	logic signed [15:0] first_x;
	logic signed [15:0] first_y;
	logic signed [15:0] first_spread;
	logic signed [15:0] first_scale;
	logic signed [15:0] second_x;
	logic signed [15:0] second_y;
	logic signed [15:0] second_spread;
	logic signed [15:0] second_scale;

	modport source (output valid, cmd, field_index, map_value, confidence, first_x, first_y,
		first_spread, first_scale, second_x, second_y, second_spread, second_scale,
		input ready);
	modport sink (input valid, cmd, field_index, map_value, confidence, first_x, first_y,
		first_spread, first_scale, second_x, second_y, second_spread, second_scale,
		output ready);
endinterface

interface caf_assoc_if;
	logic               valid;
	logic               ready;
	logic               direction;
	logic [4:0]         field_out;
	logic [15:0]        score;
	logic signed [21:0] from_x;
	logic signed [21:0] from_y;
	logic signed [21:0] from_spread;
	logic signed [21:0] from_scale;
	logic signed [21:0] to_x;
	logic signed [21:0] to_y;
	logic signed [21:0] to_spread;
	logic signed [21:0] to_scale;
	logic               last;

	modport source (output valid, direction, field_out, score, from_x, from_y, from_spread,
		from_scale, to_x, to_y, to_spread, to_scale, last, input ready);
	modport sink (input valid, direction, field_out, score, from_x, from_y, from_spread,
		from_scale, to_x, to_y, to_spread, to_scale, last, output ready);
endinterface

// File: src/caf_ram.sv
module caf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] ra_addr,
	output logic [WIDTH-1:0]         ra_data,
	input  logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic [WIDTH-1:0]         rb_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end
endmodule

// File: src/caf_front.sv
module caf_front
	import caf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  caf_cfg_t   cfg,
	caf_cell_if.sink   cells,
	input  caf_qstat_t qstat,
	output logic       push,
	output caf_rec_t   rec
);
	// stage 1: registered input item
	logic        v_s1;
	logic        cmd_s1;
	logic [4:0]  field_s1;
	logic [15:0] mval_s1, conf_s1;
	logic signed [15:0] raw_s1 [8];

	// stage 2: map data back from memory
	logic        v_s2, on_fwd_s2, on_bwd_s2;
	logic [4:0]  field_s2;
	logic [15:0] conf_s2;
	coord_t [3:0] first_s2, second_s2;

	// stage 3: weighted map products
	logic        v_s3;
	logic [4:0]  field_s3;
	logic [15:0] conf_s3;
	logic [30:0] prod_fwd_s3, prod_bwd_s3;
	coord_t [3:0] first_s3, second_s3;

	// stage 4: new scores
	logic        v_s4;
	logic [4:0]  field_s4;
	logic [15:0] score_fwd_s4, score_bwd_s4;
	coord_t [3:0] first_s4, second_s4;

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [PLANE_W-1:0] plane_q;

	logic [2:0] inflight;
	logic       accept;

	assign inflight = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign cells.ready = (5'(qstat.count) + 5'(inflight)) < 5'(QDEPTH);
	assign accept = cells.valid && cells.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cells.cmd;
			field_s1  <= cells.field_index;
			mval_s1   <= cells.map_value;
			conf_s1   <= cells.confidence;
			raw_s1[0] <= cells.first_x;
			raw_s1[1] <= cells.first_y;
			raw_s1[2] <= cells.first_spread;
			raw_s1[3] <= cells.first_scale;
			raw_s1[4] <= cells.second_x;
			raw_s1[5] <= cells.second_y;
			raw_s1[6] <= cells.second_spread;
			raw_s1[7] <= cells.second_scale;
		end
	end

	// stage 1 work: scale endpoints, decide map lookups, handle loads
	logic [15:0] conf_sat, mval_sat;
	logic        keep_cell, is_load;
	coord_t [3:0] first_c, second_c;
	logic [13:0] xlim, ylim;
	logic        field_ok, on_fwd, on_bwd;
	logic [MAP_AW-1:0] addr_fwd, addr_bwd, waddr;
	logic [15:0] rd_fwd, rd_bwd;

	always_comb begin
		conf_sat  = (conf_s1 > ONE_Q15) ? ONE_Q15 : conf_s1;
		mval_sat  = (mval_s1 > ONE_Q15) ? ONE_Q15 : mval_s1;
		keep_cell = conf_sat >= cfg.threshold;
		is_load   = v_s1 && (cmd_s1 == CMD_LOAD);
		for (int k = 0; k < 4; k++) begin
			first_c[k]  = scale_coord(raw_s1[k], cfg.stride);
			second_c[k] = scale_coord(raw_s1[k+4], cfg.stride);
		end
		xlim     = {cfg.width - 8'd1, 6'd0};
		ylim     = {cfg.height - 8'd1, 6'd0};
		field_ok = 7'(field_s1) < cfg.fields;
		// forward looks up the second endpoint, backward the first
		on_fwd = field_ok && !second_c[0][21] && !second_c[1][21]
			&& (second_c[0][20:0] <= 21'(xlim)) && (second_c[1][20:0] <= 21'(ylim));
		on_bwd = field_ok && !first_c[0][21] && !first_c[1][21]
			&& (first_c[0][20:0] <= 21'(xlim)) && (first_c[1][20:0] <= 21'(ylim));
		addr_fwd = {field_s1, second_c[1][ROW_W+5:6], second_c[0][COL_W+5:6]};
		addr_bwd = {field_s1, first_c[1][ROW_W+5:6], first_c[0][COL_W+5:6]};
		waddr    = {plane_q, row_q, col_q};
	end

	caf_ram #(.WIDTH(16), .DEPTH(MAP_DEPTH)) u_map (
		.clk     (clk),
		.we      (is_load),
		.waddr   (waddr),
		.wdata   (mval_sat),
		.ra_addr (addr_fwd),
		.ra_data (rd_fwd),
		.rb_addr (addr_bwd),
		.rb_data (rd_bwd)
	);

	// raster load position: column, then row, then plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
		end else if (is_load) begin
			if (8'(col_q) + 8'd1 >= cfg.width) begin
				col_q <= '0;
				if (8'(row_q) + 8'd1 >= cfg.height) begin
					row_q <= '0;
					if (7'(plane_q) + 7'd1 >= cfg.fields) begin
						plane_q <= '0;
					end else begin
						plane_q <= plane_q + 1'b1;
					end
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && (cmd_s1 == CMD_CELL) && keep_cell;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	logic [15:0] m_fwd, m_bwd, rem_w;
	logic [30:0] fac_fwd, fac_bwd;
	logic [46:0] big_fwd, big_bwd;

	always_comb begin
		m_fwd   = on_fwd_s2 ? rd_fwd : 16'd0;
		m_bwd   = on_bwd_s2 ? rd_bwd : 16'd0;
		rem_w   = ONE_Q15 - cfg.floor_w;
		fac_fwd = {cfg.floor_w[15:0], 15'd0} + prod_fwd_s3;
		fac_bwd = {cfg.floor_w[15:0], 15'd0} + prod_bwd_s3;
		big_fwd = 47'(conf_s3) * 47'(fac_fwd);
		big_bwd = 47'(conf_s3) * 47'(fac_bwd);
	end

	always_ff @(posedge clk) begin
		on_fwd_s2    <= on_fwd;
		on_bwd_s2    <= on_bwd;
		field_s2     <= field_s1;
		conf_s2      <= conf_sat;
		first_s2     <= first_c;
		second_s2    <= second_c;

		field_s3     <= field_s2;
		conf_s3      <= conf_s2;
		prod_fwd_s3  <= 31'(32'(rem_w) * 32'(m_fwd));
		prod_bwd_s3  <= 31'(32'(rem_w) * 32'(m_bwd));
		first_s3     <= first_s2;
		second_s3    <= second_s2;

		field_s4     <= field_s3;
		score_fwd_s4 <= big_fwd[45:30];
		score_bwd_s4 <= big_bwd[45:30];
		first_s4     <= first_s3;
		second_s4    <= second_s3;
	end

	always_comb begin
		rec.field     = field_s4;
		rec.keep_fwd  = score_fwd_s4 > cfg.threshold;
		rec.keep_bwd  = score_bwd_s4 > cfg.threshold;
		rec.score_fwd = score_fwd_s4;
		rec.score_bwd = score_bwd_s4;
		rec.first     = first_s4;
		rec.second    = second_s4;
		push          = v_s4 && (rec.keep_fwd || rec.keep_bwd);
	end
endmodule

// File: src/caf_queue.sv
module caf_queue
	import caf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  caf_rec_t   push_rec,
	input  logic       pop,
	output caf_rec_t   head,
	output caf_qstat_t qstat
);
	caf_rec_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   count_q;

	assign head            = slot_q[rd_q];
	assign qstat.count     = count_q;
	assign qstat.not_empty = count_q != '0;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// File: src/caf_back.sv
module caf_back
	import caf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  caf_rec_t   head,
	input  caf_qstat_t qstat,
	output logic       pop,
	caf_assoc_if.source assocs
);
	logic valid_q;
	logic bwd_pending_q;
	logic load;
	logic emit_fwd;

	assign load     = (!valid_q || assocs.ready) && qstat.not_empty;
	assign emit_fwd = !bwd_pending_q && head.keep_fwd;
	assign pop      = load && !(emit_fwd && head.keep_bwd);
	assign assocs.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			bwd_pending_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (assocs.ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				bwd_pending_q <= emit_fwd && head.keep_bwd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			assocs.field_out <= head.field;
			if (emit_fwd) begin
				assocs.direction   <= DIR_FORWARD;
				assocs.score       <= head.score_fwd;
				assocs.from_x      <= head.first[0];
				assocs.from_y      <= head.first[1];
				assocs.from_spread <= head.first[2];
				assocs.from_scale  <= head.first[3];
				assocs.to_x        <= head.second[0];
				assocs.to_y        <= head.second[1];
				assocs.to_spread   <= head.second[2];
				assocs.to_scale    <= head.second[3];
				assocs.last        <= !head.keep_bwd;
			end else begin
				assocs.direction   <= DIR_BACKWARD;
				assocs.score       <= head.score_bwd;
				assocs.from_x      <= head.second[0];
				assocs.from_y      <= head.second[1];
				assocs.from_spread <= head.second[2];
				assocs.from_scale  <= head.second[3];
				assocs.to_x        <= head.first[0];
				assocs.to_y        <= head.first[1];
				assocs.to_spread   <= head.first[2];
				assocs.to_scale    <= head.first[3];
				assocs.last        <= 1'b1;
			end
		end
	end
endmodule

// File: src/caf_association_rescore_filter.sv
// Association rescoring filter. Load items (cmd 0) fill a confidence map of 32 planes of
// 128 by 128 Q1.15 values in raster order; cell items (cmd 1) are scaled by the stride,
// looked up in the map at both endpoints through the two read ports of the map memory, and
// give up to two associations, forward then backward, the final one flagged by last. One
// item enters per cycle: the front takes an item whenever the queue has room for every item
// still in its four stages, and the back delivers one association per cycle while the
// receiver is ready, so a cell that keeps both directions leaves the queue only with its
// backward association. A result passes the four front stages, the queue and the output
// register. The map is not cleared after reset; read entries must be loaded.
module caf_association_rescore_filter
	import caf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	caf_cell_if.sink    cells,
	caf_assoc_if.source assocs
);
	logic [15:0] threshold_q, floor_q;
	logic [6:0]  stride_q;
	logic [7:0]  width_q, height_q;
	logic [5:0]  fields_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	caf_cfg_t   cfg;
	caf_qstat_t qstat;
	caf_rec_t   push_rec, head;
	logic       push, pop;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// hold raw register values; clamp on the way into the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= 16'd6554;
			floor_q     <= 16'd3277;
			stride_q    <= 7'd8;
			width_q     <= 8'd128;
			height_q    <= 8'd128;
			fields_q    <= 6'd32;
		end else if (wr_en) begin
			case (reg_idx)
				REG_THRESHOLD: threshold_q <= pwdata[15:0];
				REG_FLOOR:     floor_q     <= pwdata[15:0];
				REG_STRIDE:    stride_q    <= pwdata[6:0];
				REG_WIDTH:     width_q     <= pwdata[7:0];
				REG_HEIGHT:    height_q    <= pwdata[7:0];
				REG_FIELDS:    fields_q    <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD: prdata = 32'(threshold_q);
			REG_FLOOR:     prdata = 32'(floor_q);
			REG_STRIDE:    prdata = 32'(stride_q);
			REG_WIDTH:     prdata = 32'(width_q);
			REG_HEIGHT:    prdata = 32'(height_q);
			REG_FIELDS:    prdata = 32'(fields_q);
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		cfg.threshold = threshold_q;
		cfg.floor_w   = (floor_q > ONE_Q15) ? ONE_Q15 : floor_q;
		cfg.stride    = (stride_q == 7'd0) ? 7'd1 : ((stride_q > 7'd64) ? 7'd64 : stride_q);
		cfg.width     = (width_q == 8'd0) ? 8'd1
			: ((width_q > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : width_q);
		cfg.height    = (height_q == 8'd0) ? 8'd1
			: ((height_q > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : height_q);
		cfg.fields    = (fields_q == 6'd0) ? 7'd1
			: ((7'(fields_q) > 7'(NUM_FIELDS)) ? 7'(NUM_FIELDS) : 7'(fields_q));
	end

	// front: accept, scale, look up and rescore
	caf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cells  (cells),
		.qstat  (qstat),
		.push   (push),
		.rec    (push_rec)
	);

	// queue of cells that give at least one association
	caf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// back: split each cell into its associations
	caf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.assocs (assocs)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		5'(qstat.count) <= 5'(QDEPTH))
		else $error("association queue overfilled");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.not_empty)
		else $error("pop from empty queue");

	a_not_last_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(assocs.valid && !assocs.last) |-> (assocs.direction == DIR_FORWARD))
		else $error("non-final item is not forward");

	a_bwd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(assocs.valid && assocs.ready && !assocs.last)
		|=> (assocs.valid && assocs.direction == DIR_BACKWARD))
		else $error("backward item does not follow forward");
endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import caf_pkg::*;

	// one input item as queued for the sender
	typedef struct packed {
		logic              cmd;
		logic [4:0]        field;
		logic [15:0]       mval;
		logic [15:0]       conf;
		logic [7:0][15:0]  pts;   // first x,y,spread,scale then second x,y,spread,scale
	} cell_item_t;

	// one association as the block should deliver it
	typedef struct packed {
		logic              dir;
		logic [4:0]        field;
		logic [15:0]       score;
		logic [3:0][21:0]  src;
		logic [3:0][21:0]  dst;
		logic              last;
	} assoc_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	caf_cell_if  cells_if ();
	caf_assoc_if assoc_if ();

	caf_association_rescore_filter dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cells(cells_if), .assocs(assoc_if)
	);

	always #5 clk = ~clk;

	// raw register copies, as written over the port
	logic [15:0] thr_reg = 16'd6554;
	logic [15:0] floor_reg = 16'd3277;
	logic [6:0]  stride_reg = 7'd8;
	logic [7:0]  width_reg = 8'd128;
	logic [7:0]  height_reg = 8'd128;
	logic [5:0]  fields_reg = 6'd32;

	// predicted map contents and load cursor
	logic [15:0] conf_map [MAP_DEPTH];
	int map_col = 0, map_row = 0, map_plane = 0;

	// generator's own view: which entries will have been written, and where loads go
	bit   gen_written [MAP_DEPTH];
	int   gen_col = 0, gen_row = 0, gen_plane = 0;

	cell_item_t pending_items [$];
	assoc_t     expected_assocs [$];

	int err_cnt = 0;
	int n_loads = 0, n_cells = 0, n_assocs = 0, n_phases = 0;
	int cycle_cnt = 0;

	function automatic int clampi(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int eff_width();
		return clampi(width_reg, 1, MAX_WIDTH);
	endfunction

	function automatic int eff_height();
		return clampi(height_reg, 1, MAX_HEIGHT);
	endfunction

	function automatic int eff_fields();
		return clampi(fields_reg, 1, NUM_FIELDS);
	endfunction

	function automatic int eff_stride();
		return clampi(stride_reg, 1, 64);
	endfunction

	// map address read for a target point, or -1 where the point reads as zero
	function automatic int lookup_addr(int field, int x, int y);
		if (field >= eff_fields() || x < 0 || y < 0) return -1;
		if (x > (eff_width() - 1) * 64 || y > (eff_height() - 1) * 64) return -1;
		return (field * MAX_HEIGHT + (y >>> 6)) * MAX_WIDTH + (x >>> 6);
	endfunction

	// raster advance; a counter already beyond a lowered limit wraps on this step
	function automatic void advance_cursor(inout int col, inout int row, inout int plane);
		if (col + 1 >= eff_width()) begin
			col = 0;
			if (row + 1 >= eff_height()) begin
				row = 0;
				plane = (plane + 1 >= eff_fields()) ? 0 : plane + 1;
			end else begin
				row++;
			end
		end else begin
			col++;
		end
	endfunction

	function automatic logic [15:0] rescored(int c, int m);
		longint f, factor;
		f = clampi(floor_reg, 0, 32768);
		factor = f * 32768 + (32768 - f) * longint'(m);
		return 16'((longint'(c) * factor) >>> 30);
	endfunction

	// work out what one accepted item does to the map and which associations it gives
	function automatic void predict_item(cell_item_t it);
		int s, c, a, m, n, idx;
		int sc [8];
		assoc_t r;
		assoc_t outs [$];
		if (it.cmd == CMD_LOAD) begin
			idx = (map_plane * MAX_HEIGHT + map_row) * MAX_WIDTH + map_col;
			conf_map[idx] = (it.mval > ONE_Q15) ? ONE_Q15 : it.mval;
			advance_cursor(map_col, map_row, map_plane);
			n_loads++;
			return;
		end
		n_cells++;
		c = (it.conf > ONE_Q15) ? 32768 : it.conf;
		if (c < thr_reg) return;
		s = eff_stride();
		for (int k = 0; k < 8; k++) sc[k] = $signed(it.pts[k]) * s;
		// forward looks up the second endpoint, backward the first
		for (int d = 0; d < 2; d++) begin
			n = (d == 0) ? 4 : 0;
			a = lookup_addr(it.field, sc[n], sc[n + 1]);
			m = (a < 0) ? 0 : conf_map[a];
			r.score = rescored(c, m);
			if (r.score > thr_reg) begin
				r.dir = (d == 0) ? DIR_FORWARD : DIR_BACKWARD;
				r.field = it.field;
				for (int k = 0; k < 4; k++) begin
					r.src[k] = 22'(sc[(d == 0) ? k : k + 4]);
					r.dst[k] = 22'(sc[(d == 0) ? k + 4 : k]);
				end
				r.last = 1'b0;
				outs = {outs, r};
			end
		end
		if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
		expected_assocs = {expected_assocs, outs};
	endfunction

	// sender: bursts of random length, random gaps
	int burst_left = 0, gap_left = 0;
	cell_item_t cur_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_if.valid <= 1'b0;
		end else begin
			if (cells_if.valid && cells_if.ready) predict_item(cur_item);
			if (!cells_if.valid || cells_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cells_if.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					cells_if.valid <= 1'b1;
					cells_if.cmd <= cur_item.cmd;
					cells_if.field_index <= cur_item.field;
					cells_if.map_value <= cur_item.mval;
					cells_if.confidence <= cur_item.conf;
					cells_if.first_x <= cur_item.pts[0];
					cells_if.first_y <= cur_item.pts[1];
					cells_if.first_spread <= cur_item.pts[2];
					cells_if.first_scale <= cur_item.pts[3];
					cells_if.second_x <= cur_item.pts[4];
					cells_if.second_y <= cur_item.pts[5];
					cells_if.second_spread <= cur_item.pts[6];
					cells_if.second_scale <= cur_item.pts[7];
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						// long runs with no gap now and then
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					cells_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern drawn at random from four modes
	int stall_mode = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assoc_if.ready <= 1'b0;
		end else begin
			if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: assoc_if.ready <= 1'b1;
				1: assoc_if.ready <= 1'($urandom_range(0, 1));
				2: assoc_if.ready <= ($urandom_range(0, 3) == 0);
				default: assoc_if.ready <= ((cycle_cnt % 8) < 5);
			endcase
		end
	end

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// compare every delivered association with the oldest prediction
	always @(posedge clk) begin
		assoc_t e;
		if (arst_n && assoc_if.valid && assoc_if.ready) begin
			if (expected_assocs.size() == 0) begin
				$error("association delivered with none expected");
				err_cnt++;
			end else begin
				e = expected_assocs.pop_front();
				n_assocs++;
				check_field("direction", e.dir, assoc_if.direction);
				check_field("field_out", e.field, assoc_if.field_out);
				check_field("score", e.score, assoc_if.score);
				check_field("from_x", e.src[0], unsigned'(assoc_if.from_x));
				check_field("from_y", e.src[1], unsigned'(assoc_if.from_y));
				check_field("from_spread", e.src[2], unsigned'(assoc_if.from_spread));
				check_field("from_scale", e.src[3], unsigned'(assoc_if.from_scale));
				check_field("to_x", e.dst[0], unsigned'(assoc_if.to_x));
				check_field("to_y", e.dst[1], unsigned'(assoc_if.to_y));
				check_field("to_spread", e.dst[2], unsigned'(assoc_if.to_spread));
				check_field("to_scale", e.dst[3], unsigned'(assoc_if.to_scale));
				check_field("last", e.last, assoc_if.last);
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// hold every input at a known value from time zero
	initial begin
		cells_if.valid = 1'b0;
		cells_if.cmd = CMD_LOAD;
		cells_if.field_index = '0;
		cells_if.map_value = '0;
		cells_if.confidence = '0;
		cells_if.first_x = '0;
		cells_if.first_y = '0;
		cells_if.first_spread = '0;
		cells_if.first_scale = '0;
		cells_if.second_x = '0;
		cells_if.second_y = '0;
		cells_if.second_spread = '0;
		cells_if.second_scale = '0;
		assoc_if.ready = 1'b0;
	end

	// write one register: setup cycle, then access cycle
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_THRESHOLD: thr_reg = val[15:0];
			REG_FLOOR:     floor_reg = val[15:0];
			REG_STRIDE:    stride_reg = val[6:0];
			REG_WIDTH:     width_reg = val[7:0];
			REG_HEIGHT:    height_reg = val[7:0];
			REG_FIELDS:    fields_reg = val[5:0];
			default: ;
		endcase
	endtask

	// hold until nothing is queued or owed, then let loads still in flight settle
	task automatic wait_drained();
		while (pending_items.size() > 0 || cells_if.valid || expected_assocs.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_load(logic [15:0] v);
		cell_item_t it;
		it = '0;
		it.cmd = CMD_LOAD;
		it.field = 5'($urandom_range(0, 31));
		it.mval = v;
		it.conf = 16'($urandom);
		for (int k = 0; k < 8; k++) it.pts[k] = 16'($urandom);
		gen_written[(gen_plane * MAX_HEIGHT + gen_row) * MAX_WIDTH + gen_col] = 1'b1;
		advance_cursor(gen_col, gen_row, gen_plane);
		pending_items = {pending_items, it};
	endtask

	// push a cell, steering any endpoint that would read an unloaded entry off the map
	task automatic push_cell(cell_item_t it);
		int s, a;
		it.cmd = CMD_CELL;
		s = eff_stride();
		for (int n = 0; n < 8; n += 4) begin
			a = lookup_addr(it.field, $signed(it.pts[n]) * s, $signed(it.pts[n + 1]) * s);
			if (a >= 0 && !gen_written[a]) it.pts[n] = 16'hFFFF;
		end
		pending_items = {pending_items, it};
	endtask

	// grid coordinate whose pixel lands near the map, a little outside on both sides
	function automatic logic [15:0] near_grid(int extent);
		int pix;
		pix = int'($urandom_range(0, extent * 64 + 127)) - 64;
		return 16'(pix / eff_stride());
	endfunction

	function automatic cell_item_t random_cell();
		cell_item_t it;
		it = '0;
		it.field = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
			: 5'($urandom_range(0, eff_fields() - 1));
		it.mval = 16'($urandom);
		case ($urandom_range(0, 3))
			0: it.conf = 16'($urandom);
			1: it.conf = 16'($urandom_range(0, 32768));
			default: it.conf = 16'(clampi(int'(thr_reg) + int'($urandom_range(0, 6000)) - 1000,
				0, 32768));
		endcase
		for (int k = 0; k < 8; k++) it.pts[k] = 16'($urandom);
		if ($urandom_range(0, 4) != 0) begin
			for (int n = 0; n < 8; n += 4) begin
				it.pts[n] = near_grid(eff_width());
				it.pts[n + 1] = near_grid(eff_height());
			end
		end
		return it;
	endfunction

	task automatic config_all(int thr, int fl, int st, int w, int h, int fc);
		reg_write(REG_THRESHOLD, thr);
		reg_write(REG_FLOOR, fl);
		reg_write(REG_STRIDE, st);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_FIELDS, fc);
	endtask

	// fill loads first, then a random mix; pause once half-way until all results are in
	task automatic run_phase(int fill, int n_rand);
		n_phases++;
		repeat (fill) push_load($urandom_range(0, 3) == 0 ? 16'($urandom)
			: 16'($urandom_range(0, 32768)));
		for (int i = 0; i < n_rand; i++) begin
			if (i == n_rand / 2) wait_drained();
			if ($urandom_range(0, 3) == 0) push_load(16'($urandom));
			else push_cell(random_cell());
		end
		wait_drained();
	endtask

	initial begin
		cell_item_t it;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// small map at the default scores, fully loaded, then the directed cells
		config_all(6554, 3277, 8, 8, 8, 2);
		push_load(16'd0);
		push_load(16'd32768);
		push_load(16'hFFFF);
		push_load(16'd32769);
		repeat (124) push_load(16'($urandom_range(0, 32768)));
		it = '0;
		// confidence zero, exactly the threshold, one below, full scale and above one
		it.conf = 16'd0;         push_cell(it);
		it.conf = 16'd6553;      push_cell(it);
		it.conf = 16'd6554;      push_cell(it);
		it.conf = 16'd32768;     push_cell(it);
		it.conf = 16'hFFFF;      push_cell(it);
		// far corner of the map, and one grid step past it on each axis
		it.pts[4] = 16'd56; it.pts[5] = 16'd56;              push_cell(it);
		it.pts[4] = 16'd57;                                  push_cell(it);
		it.pts[4] = 16'd56; it.pts[5] = 16'd57;              push_cell(it);
		// fractional positions floor to the pixel
		it.pts[0] = 16'd7; it.pts[1] = 16'd15; it.pts[4] = 16'd9; it.pts[5] = 16'd23;
		push_cell(it);
		// negative coordinates, extremes of every endpoint field
		for (int k = 0; k < 8; k++) it.pts[k] = (k % 2) ? 16'h8000 : 16'h7FFF;
		push_cell(it);
		for (int k = 0; k < 8; k++) it.pts[k] = (k % 2) ? 16'h7FFF : 16'h8000;
		push_cell(it);
		// field beyond the planes in use reads zero
		it.pts = '0;
		it.field = 5'd31;        push_cell(it);
		it.field = 5'd1;         push_cell(it);
		it.field = 5'd2;         push_cell(it);
		run_phase(0, 150);

		// threshold and floor at zero, unit stride, one wide plane
		config_all(0, 0, 1, 128, 2, 1);
		run_phase(256, 150);

		// full-scale threshold and floor, largest stride, single pixel map
		config_all(32768, 32768, 64, 1, 1, 1);
		run_phase(1, 80);

		// out-of-range values: clamped stride, size and floor, raw threshold
		config_all(16'hFFFF, 16'hFFFF, 0, 0, 200, 0);
		run_phase(128, 60);
		config_all(100, 40000, 127, 3, 3, 63);
		run_phase(32 * 9, 100);

		// lower the width while the load column already lies beyond it
		config_all(3000, 10000, 4, 16, 4, 2);
		run_phase(10, 50);
		config_all(3000, 10000, 4, 4, 4, 2);
		run_phase(40, 100);

		// a random mid-range setting
		config_all($urandom_range(0, 20000), $urandom_range(0, 32768), $urandom_range(1, 64),
			$urandom_range(2, 6), $urandom_range(2, 6), $urandom_range(1, 4));
		run_phase(eff_width() * eff_height() * eff_fields(), 120);

		$display("Ran %0d phases: %0d loads, %0d cells, %0d associations checked",
			n_phases, n_loads, n_cells, n_assocs);
		if (err_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: files.f
src/caf_pkg.sv
src/caf_if.sv
src/caf_ram.sv
src/caf_front.sv
src/caf_queue.sv
src/caf_back.sv
src/caf_association_rescore_filter.sv
tb/tb.sv
